// File: rtl/cdad_pkg.sv
// ----------------------------------------------------------------------------
// cdad_pkg
// Shared constants, types and the month length table for the date adder.
// ----------------------------------------------------------------------------
package cdad_pkg;

    localparam int MAX_ADD_DAYS_DEF = 4095;

    // Widths fixed by the port fields.
    localparam int DAY_IW   = 6;
    localparam int DAY_OW   = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int COUNT_W  = 12;

    // The year register is carried one bit wider than the port; out_year takes
    // only its low bits, and the leap rule works from the year modulo 400.
    localparam int YEAR_CW  = YEAR_W + 1;

    // Year modulo 400 is found by restoring subtraction of 400 shifted left.
    localparam int YEAR_MOD  = 400;
    localparam int CENTURY   = 100;
    localparam int MOD_STEPS = 6;
    localparam int STEP_W    = 3;
    localparam int LAST_MONTH = 12;

    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);

    typedef struct packed {
        logic              load;
        logic              mod_step;
        logic [STEP_W-1:0] mod_shift;
        logic              sanitize;
        logic              carry;
    } cdad_cmd_t;

    typedef struct packed {
        logic carry_more;
    } cdad_sts_t;

    function automatic logic [DAY_OW-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_OW-1:0] len;
        unique case (m)
            4'd2:                                      len = leap ? 5'd29 : 5'd28;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            default:                                   len = 5'd30;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/calendar_date_add_days.sv
// ----------------------------------------------------------------------------
// calendar_date_add_days
// Adds a day count to a Gregorian date, carrying one month per cycle.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Signals
//  input     start & !busy      in_day, in_month, in_year, add_days
//  result    done (one cycle)   out_day, out_month, out_year
//
//  done rises once the year has been reduced modulo 400, the date has been
//  cleaned up and the carry loop has stepped over every month boundary
//  crossed, one month per cycle, and seen that no carry is left. The result
//  beat is taken at the edge that ends the done cycle. busy falls at that
//  same edge; no new item is accepted while busy is high.
//  Reset is asynchronous and returns the sequencer to idle. The receiver
//  cannot stall; the result ports hold their values until the next item is
//  accepted.
module calendar_date_add_days
    import cdad_pkg::*;
#(
    parameter int MAX_ADD_DAYS = MAX_ADD_DAYS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [DAY_IW-1:0]  in_day,
    input  logic [MONTH_W-1:0] in_month,
    input  logic [YEAR_W-1:0]  in_year,
    input  logic [COUNT_W-1:0] add_days,
    output logic               done,
    output logic [DAY_OW-1:0]  out_day,
    output logic [MONTH_W-1:0] out_month,
    output logic [YEAR_W-1:0]  out_year
);

    cdad_cmd_t cmd;
    cdad_sts_t sts;

    cdad_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    cdad_dp #(
        .MAX_ADD_DAYS (MAX_ADD_DAYS)
    ) u_dp (
        .clk       (clk),
        .cmd       (cmd),
        .in_day    (in_day),
        .in_month  (in_month),
        .in_year   (in_year),
        .add_days  (add_days),
        .sts       (sts),
        .out_day   (out_day),
        .out_month (out_month),
        .out_year  (out_year)
    );

endmodule

// File: rtl/cdad_ctrl.sv
// ----------------------------------------------------------------------------
// cdad_ctrl
// Sequencer for the date adder: year reduction, date clean-up, month carry.
// ----------------------------------------------------------------------------
module cdad_ctrl
    import cdad_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  cdad_sts_t sts,
    output cdad_cmd_t cmd,
    output logic      busy,
    output logic      done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_SANE,
        S_CARRY,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        busy_next     = busy_reg;
        done_next     = 1'b0;
        cmd           = '0;
        cmd.mod_shift = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MOD;
                    step_next  = STEP_W'(MOD_STEPS - 1);
                    busy_next  = 1'b1;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_SANE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            S_SANE:
            begin
                cmd.sanitize = 1'b1;
                state_next   = S_CARRY;
            end
            S_CARRY:
            begin
                cmd.carry = 1'b1;
                if (!sts.carry_more)
                begin
                    state_next = S_DONE;
                    done_next  = 1'b1;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// File: rtl/cdad_dp.sv
// ----------------------------------------------------------------------------
// cdad_dp
// Datapath of the date adder: date registers, year modulo 400, month carry.
// ----------------------------------------------------------------------------
module cdad_dp
    import cdad_pkg::*;
#(
    parameter int MAX_ADD_DAYS = MAX_ADD_DAYS_DEF
)
(
    input  logic                clk,
    input  cdad_cmd_t           cmd,
    input  logic [DAY_IW-1:0]   in_day,
    input  logic [MONTH_W-1:0]  in_month,
    input  logic [YEAR_W-1:0]   in_year,
    input  logic [COUNT_W-1:0]  add_days,
    output cdad_sts_t           sts,
    output logic [DAY_OW-1:0]   out_day,
    output logic [MONTH_W-1:0]  out_month,
    output logic [YEAR_W-1:0]   out_year
);

    // Room for the clamped count plus any raw input day.
    localparam int DW = $clog2(MAX_ADD_DAYS + 64);
    localparam int CW = (DW > COUNT_W) ? DW : COUNT_W;
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_ADD_DAYS);

    logic [DW-1:0]      day_reg, day_next;
    logic [DW-1:0]      count_reg, count_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [YEAR_CW-1:0] year_reg, year_next;
    logic [YEAR_W-1:0]  rem_reg, rem_next;

    logic [CW-1:0]      count_wide;
    logic [YEAR_CW-1:0] sub_val;
    logic [YEAR_CW-1:0] rem_diff;
    logic               leap;
    logic [DAY_OW-1:0]  mlen;
    logic [DW-1:0]      mlen_w;
    logic               day_bad;

    assign count_wide = CW'(add_days);

    // rem_reg holds the year modulo 400 once reduction is over.
    assign leap = (rem_reg == '0)
               || ((rem_reg[1:0] == 2'b00)
                   && (rem_reg != YEAR_W'(CENTURY))
                   && (rem_reg != YEAR_W'(2 * CENTURY))
                   && (rem_reg != YEAR_W'(3 * CENTURY)));

    assign mlen   = month_len(month_reg, leap);
    assign mlen_w = DW'(mlen);

    assign sub_val  = YEAR_CW'(YEAR_MOD) << cmd.mod_shift;
    assign rem_diff = YEAR_CW'(rem_reg) - sub_val;
    assign day_bad  = (day_reg == '0) || (day_reg > mlen_w);

    assign sts.carry_more = day_reg > mlen_w;

    always_comb
    begin
        day_next   = day_reg;
        count_next = count_reg;
        month_next = month_reg;
        year_next  = year_reg;
        rem_next   = rem_reg;
        priority if (cmd.load)
        begin
            day_next   = DW'(in_day);
            count_next = (count_wide > COUNT_MAX) ? DW'(COUNT_MAX) : DW'(count_wide);
            month_next = ((in_month == '0) || (in_month > MONTH_W'(LAST_MONTH)))
                       ? '0 : in_month;
            year_next  = YEAR_CW'(in_year);
            rem_next   = in_year;
        end
        else if (cmd.mod_step)
        begin
            if (YEAR_CW'(rem_reg) >= sub_val)
            begin
                rem_next = rem_diff[YEAR_W-1:0];
            end
        end
        else if (cmd.sanitize)
        begin
            day_next = (day_bad ? '0 : day_reg) + count_reg;
        end
        else if (cmd.carry && sts.carry_more)
        begin
            day_next = day_reg - mlen_w;
            if (month_reg == MONTH_W'(LAST_MONTH))
            begin
                // New year: later month lengths follow its leap rule.
                month_next = MONTH_W'(1);
                year_next  = year_reg + 1'b1;
                rem_next   = (rem_reg == YEAR_W'(YEAR_MOD - 1)) ? '0 : rem_reg + 1'b1;
            end
            else
            begin
                month_next = month_reg + 1'b1;
            end
        end
        else
        begin
            // No command, or a carry with none left: the date registers hold.
            day_next = day_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        day_reg   <= day_next;
        count_reg <= count_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        rem_reg   <= rem_next;
    end

    assign out_day   = day_reg[DAY_OW-1:0];
    assign out_month = month_reg;
    assign out_year  = year_reg[YEAR_W-1:0];

endmodule

// File: verif/calendar_date_add_days_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_add_days_tb
// Drives starting dates and day counts into the date adder and checks every
// result beat against a date predictor running in the testbench. A short
// directed table covers field extremes, leap rules and invalid dates. Random
// dates follow in phases with and without gaps between beats.
// ----------------------------------------------------------------------------
module calendar_date_add_days_tb;
    import cdad_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_LIMIT  = 1_000;
    localparam int RANDOM_DATES = 1_520;
    localparam int NUM_PHASES   = 4;

    typedef struct packed {
        logic [DAY_OW-1:0]  day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_t;

    typedef struct packed {
        logic [DAY_IW-1:0]  day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [COUNT_W-1:0] count;
        logic               typed;
        date_t              want;
    } date_row_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               start    = 1'b0;
    logic [DAY_IW-1:0]  in_day   = '0;
    logic [MONTH_W-1:0] in_month = '0;
    logic [YEAR_W-1:0]  in_year  = '0;
    logic [COUNT_W-1:0] add_days = '0;
    logic               busy;
    logic               done;
    logic [DAY_OW-1:0]  out_day;
    logic [MONTH_W-1:0] out_month;
    logic [YEAR_W-1:0]  out_year;

    date_t     pending_dates[$];
    date_row_t directed_rows[$];
    date_t     arrived_date;
    date_t     oldest_date;

    int errors        = 0;
    int cycle_count   = 0;
    int dates_sent    = 0;
    int dates_checked = 0;
    int bad_inputs    = 0;
    int year_carries  = 0;
    int idle_pct      = 0;

    calendar_date_add_days dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_day    (in_day),
        .in_month  (in_month),
        .in_year   (in_year),
        .add_days  (add_days),
        .done      (done),
        .out_day   (out_day),
        .out_month (out_month),
        .out_year  (out_year)
    );

    always #4 clk = ~clk;

    function automatic bit leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m,
                                                  input int unsigned y);
        if (m == MONTH_FEB)
            return leap_year(y) ? 29 : 28;
        if (m inside {1, 3, 5, 7, 8, 10, 12})
            return 31;
        return 30;
    endfunction

    // Month 0 stands for any invalid month and is treated as a 30-day month.
    function automatic date_t advance_date(input logic [DAY_IW-1:0]  day_in,
                                           input logic [MONTH_W-1:0] month_in,
                                           input logic [YEAR_W-1:0]  year_in,
                                           input logic [COUNT_W-1:0] count_in);
        int unsigned d;
        int unsigned m;
        int unsigned y;
        int unsigned n;
        date_t       r;
        d = day_in;
        m = month_in;
        y = year_in;
        n = count_in;
        if (n > MAX_ADD_DAYS_DEF)
            n = MAX_ADD_DAYS_DEF;
        if (m < 1 || m > LAST_MONTH)
            m = 0;
        if (d == 0 || d > days_in_month(m, y))
            d = 0;
        d += n;
        while (d > days_in_month(m, y))
        begin
            d -= days_in_month(m, y);
            m++;
            if (m > LAST_MONTH)
            begin
                m = 1;
                y++;
            end
        end
        r.day   = DAY_OW'(d);
        r.month = MONTH_W'(m);
        r.year  = YEAR_W'(y);
        return r;
    endfunction

    // Presents one date and waits for the edge at which the block takes it.
    task automatic send_date(input logic [DAY_IW-1:0]  day_in,
                             input logic [MONTH_W-1:0] month_in,
                             input logic [YEAR_W-1:0]  year_in,
                             input logic [COUNT_W-1:0] count_in,
                             input logic               typed,
                             input date_t              typed_want);
        date_t want;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        in_day   <= day_in;
        in_month <= month_in;
        in_year  <= year_in;
        add_days <= count_in;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        want = typed ? typed_want : advance_date(day_in, month_in, year_in, count_in);
        pending_dates.push_back(want);
        dates_sent++;
        if (month_in < 1 || month_in > LAST_MONTH || day_in == 0
            || day_in > days_in_month(month_in, year_in))
            bad_inputs++;
        if (want.year != year_in)
            year_carries++;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Result beats cannot be held off, so each one is taken at the edge that
    // ends its strobe cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            arrived_date = '{out_day, out_month, out_year};
            if (pending_dates.size() == 0)
            begin
                $display("%0t: result beat with no date pending, got %0d-%0d-%0d",
                         $time, out_year, out_month, out_day);
                errors++;
            end
            else
            begin
                oldest_date = pending_dates.pop_front();
                check_field("out_day", oldest_date.day, arrived_date.day);
                check_field("out_month", oldest_date.month, arrived_date.month);
                check_field("out_year", oldest_date.year, arrived_date.year);
                dates_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        date_row_t          row;
        logic [DAY_IW-1:0]  r_day;
        logic [MONTH_W-1:0] r_month;
        logic [YEAR_W-1:0]  r_year;
        logic [COUNT_W-1:0] r_count;
        int                 drain;
        int                 phase_idle[NUM_PHASES];

        // Rows with a typed result can be read straight off the calendar.
        directed_rows.push_back('{6'd0,  4'd0,  14'd0,     12'd0,    1'b1, '{5'd0,  4'd0,  14'd0}});
        directed_rows.push_back('{6'd63, 4'd15, 14'd16383, 12'd4095, 1'b0, '0});
        directed_rows.push_back('{6'd31, 4'd12, 14'd9999,  12'd1,    1'b1, '{5'd1,  4'd1,  14'd10000}});
        directed_rows.push_back('{6'd29, 4'd2,  14'd2000,  12'd0,    1'b1, '{5'd29, 4'd2,  14'd2000}});
        directed_rows.push_back('{6'd29, 4'd2,  14'd1900,  12'd0,    1'b1, '{5'd0,  4'd2,  14'd1900}});
        directed_rows.push_back('{6'd29, 4'd2,  14'd2004,  12'd1,    1'b1, '{5'd1,  4'd3,  14'd2004}});
        directed_rows.push_back('{6'd28, 4'd2,  14'd2100,  12'd1,    1'b1, '{5'd1,  4'd3,  14'd2100}});
        directed_rows.push_back('{6'd28, 4'd2,  14'd2023,  12'd1,    1'b1, '{5'd1,  4'd3,  14'd2023}});
        directed_rows.push_back('{6'd1,  4'd1,  14'd2024,  12'd4095, 1'b0, '0});
        directed_rows.push_back('{6'd15, 4'd0,  14'd2023,  12'd20,   1'b1, '{5'd5,  4'd1,  14'd2023}});
        directed_rows.push_back('{6'd31, 4'd0,  14'd5,     12'd0,    1'b1, '{5'd0,  4'd0,  14'd5}});
        directed_rows.push_back('{6'd0,  4'd7,  14'd100,   12'd0,    1'b1, '{5'd0,  4'd7,  14'd100}});
        directed_rows.push_back('{6'd0,  4'd7,  14'd100,   12'd31,   1'b1, '{5'd31, 4'd7,  14'd100}});
        directed_rows.push_back('{6'd0,  4'd13, 14'd0,     12'd31,   1'b1, '{5'd1,  4'd1,  14'd0}});
        directed_rows.push_back('{6'd31, 4'd12, 14'd16383, 12'd1,    1'b1, '{5'd1,  4'd1,  14'd0}});
        directed_rows.push_back('{6'd1,  4'd1,  14'd0,     12'd365,  1'b0, '0});
        directed_rows.push_back('{6'd30, 4'd4,  14'd2023,  12'd1,    1'b1, '{5'd1,  4'd5,  14'd2023}});
        directed_rows.push_back('{6'd31, 4'd4,  14'd2023,  12'd0,    1'b1, '{5'd0,  4'd4,  14'd2023}});
        directed_rows.push_back('{6'd32, 4'd1,  14'd2023,  12'd0,    1'b1, '{5'd0,  4'd1,  14'd2023}});
        directed_rows.push_back('{6'd1,  4'd3,  14'd1,     12'd4095, 1'b0, '0});
        directed_rows.push_back('{6'd63, 4'd12, 14'd16383, 12'd4095, 1'b0, '0});
        directed_rows.push_back('{6'd42, 4'd10, 14'd5461,  12'd2730, 1'b0, '0});
        directed_rows.push_back('{6'd21, 4'd5,  14'd10922, 12'd1365, 1'b0, '0});
        directed_rows.push_back('{6'd1,  4'd14, 14'd400,   12'd0,    1'b1, '{5'd1,  4'd0,  14'd400}});

        phase_idle[0] = 0;
        phase_idle[1] = 88;
        phase_idle[2] = 0;
        phase_idle[3] = 8;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_date(row.day, row.month, row.year, row.count, row.typed, row.want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            idle_pct = phase_idle[p];
            for (int k = 0; k < RANDOM_DATES / NUM_PHASES; k++)
            begin
                r_day   = ($urandom_range(0, 9) < 7) ? DAY_IW'($urandom_range(1, 31))
                                                     : DAY_IW'($urandom_range(0, 63));
                r_month = ($urandom_range(0, 19) < 17) ? MONTH_W'($urandom_range(1, 12))
                                                       : MONTH_W'($urandom_range(0, 15));
                case ($urandom_range(0, 3))
                    0: r_year = YEAR_W'($urandom_range(0, 16383));
                    1: r_year = YEAR_W'($urandom_range(1583, 2500));
                    // Close to a century so that both leap exceptions are met.
                    2: r_year = YEAR_W'($urandom_range(0, 163) * 100 + $urandom_range(0, 8));
                    default: r_year = YEAR_W'($urandom_range(16360, 16383));
                endcase
                // Long counts keep the block busy longest, so most beats carry short
                // ones.
                case ($urandom_range(0, 19))
                    0, 1: r_count = COUNT_W'($urandom_range(0, 4095));
                    2: r_count = COUNT_W'($urandom_range(3900, 4095));
                    3, 4, 5, 6, 7, 8, 9: r_count = COUNT_W'($urandom_range(0, 400));
                    default: r_count = COUNT_W'($urandom_range(0, 62));
                endcase
                send_date(r_day, r_month, r_year, r_count, 1'b0, '0);
            end
        end
        start <= 1'b0;

        drain = 0;
        while (pending_dates.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20) @(posedge clk);
        if (pending_dates.size() != 0)
        begin
            $display("%0t: %0d dates still pending at the end", $time,
                     pending_dates.size());
            errors++;
        end

        $display("Sent %0d dates (%0d from the directed table) over %0d gap phases; %0d checked.",
                 dates_sent, directed_rows.size(), NUM_PHASES, dates_checked);
        $display("%0d had an invalid month or day, %0d carried into a later year.",
                 bad_inputs, year_carries);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
